FILE: hw/rtl/spectral_bin_gain_matcher_assert.svh
// assertion macros for the spectral bin gain matcher
// expects clk and arst_n in the scope of the module that uses them
`ifndef SPECTRAL_BIN_GAIN_MATCHER_ASSERT_SVH
`define SPECTRAL_BIN_GAIN_MATCHER_ASSERT_SVH

// same-cycle implication
`define SBGM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBGM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/sbgm_pkg.sv
// shared constants and types of the spectral bin gain matcher
// no dependencies
`default_nettype none

package sbgm_pkg;

	localparam int BINS_DEF           = 1024;
	localparam int SAMPLE_WIDTH_DEF   = 24;
	localparam int GAIN_FRAC_BITS_DEF = 16;

	// stored gain width and width of the new magnitude
	localparam int GAIN_WIDTH = 24;
	localparam int N_WIDTH    = 32;

	localparam int CFG_IDX_WIDTH  = 2;
	localparam int CFG_DATA_WIDTH = 8;

	localparam logic [CFG_IDX_WIDTH-1:0] CFG_MODE  = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_CURVE = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_EPS   = 2'd2;

	localparam logic [7:0] EPS_RESET = 8'd1;

	typedef enum logic [1:0] {
		MODE_LEARN = 2'd0,
		MODE_GUESS = 2'd1,
		MODE_APPLY = 2'd2,
		MODE_INV   = 2'd3
	} mode_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spectral_bin_gain_matcher.sv
// top level of the spectral bin gain matcher: magnitude, ratio and rescale pipeline
// depends on sbgm_pkg and spectral_bin_gain_matcher_assert.svh
`default_nettype none

// One bin (or one gain table write) enters per cycle while item_stall is low; every item
// gives exactly one result, in order. The pipeline holds the bit-per-stage square root
// pipelines for the magnitudes and the two restoring dividers, one quotient bit per stage.
// The learned gains sit in a BINS x 24 memory read at the input transfer; a write item
// stores its gain at its own input transfer, so a later bin of the same index sees it.
// Entries never written read back undefined; there is no clearing pass. BINS must be a
// power of two, bin_index is taken modulo BINS. A stalled result is held in the output
// register and one more result in a skid stage before the input stalls.

`include "spectral_bin_gain_matcher_assert.svh"

module spectral_bin_gain_matcher import sbgm_pkg::*; #(
	parameter int BINS           = BINS_DEF,
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [CFG_IDX_WIDTH-1:0]         cfg_index,
	input  wire logic [CFG_DATA_WIDTH-1:0]        cfg_data,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic                             op,
	input  wire logic [9:0]                       bin_index,
	input  wire logic signed [SAMPLE_WIDTH-1:0]   sig_re,
	input  wire logic signed [SAMPLE_WIDTH-1:0]   sig_im,
	input  wire logic signed [SAMPLE_WIDTH-1:0]   ref_re,
	input  wire logic signed [SAMPLE_WIDTH-1:0]   ref_im,
	input  wire logic [GAIN_WIDTH-1:0]            gain_value,
	output logic                                  res_valid,
	input  wire logic                             res_stall,
	output logic                                  is_bin,
	output logic signed [SAMPLE_WIDTH-1:0]        out_re,
	output logic signed [SAMPLE_WIDTH-1:0]        out_im,
	output logic [SAMPLE_WIDTH-1:0]               out_magn
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int F    = GAIN_FRAC_BITS;
	localparam int AW   = $clog2(BINS);
	localparam int SQW  = 2 * SW;
	localparam int GEW  = GAIN_WIDTH + 1;
	localparam int NW   = N_WIDTH;
	localparam int D1V  = (SW > GEW) ? SW : GEW;
	localparam int D1W  = D1V + F + 1;
	localparam int PN   = SW + NW + 1;
	localparam int PW   = NW + GEW;

	// stage positions along the pipeline
	localparam int ISQ0 = 1;
	localparam int PRE  = ISQ0 + SW;
	localparam int DV1  = PRE + 1;
	localparam int PST  = DV1 + D1W;
	localparam int MUL  = PST + 1;
	localparam int RND  = MUL + 1;
	localparam int SCL  = RND + 1;
	localparam int DV2  = SCL + 1;
	localparam int SAT  = DV2 + PN;
	localparam int OSQ  = SAT + 1;
	localparam int OIS  = OSQ + 1;
	localparam int LAST = OIS + SW;

	localparam logic [GEW-1:0] ONE_G   = GEW'(1) << F;
	localparam logic [NW-1:0]  ONE_N   = NW'(1) << F;
	localparam logic [NW-1:0]  N_MAX   = {NW{1'b1}};
	localparam logic [PW:0]    HALF_P  = (PW + 1)'(1) << (F - 1);
	localparam logic [PN-1:0]  NEG_LIM = PN'(1) << (SW - 1);
	localparam logic [PN-1:0]  POS_LIM = NEG_LIM - PN'(1);

	typedef struct packed {
		logic                  is_wr;
		logic signed [SW-1:0]  sr;
		logic signed [SW-1:0]  si;
		logic signed [SW-1:0]  rr;
		logic signed [SW-1:0]  ri;
		logic [GEW-1:0]        g;
		logic [SQW-1:0]        v_sig;
		logic [SQW-1:0]        r_sig;
		logic [SQW-1:0]        v_ref;
		logic [SQW-1:0]        r_ref;
		logic [SW-1:0]         sm;
		logic                  use_div;
		logic [D1W-1:0]        d1_num;
		logic [D1V-1:0]        d1_dvs;
		logic [D1V-1:0]        d1_rem;
		logic [NW-1:0]         n;
		logic [PW-1:0]         prod;
		logic [PN-1:0]         re_num;
		logic [PN-1:0]         im_num;
		logic [SW-1:0]         re_rem;
		logic [SW-1:0]         im_rem;
		logic [SW-1:0]         o_re;
		logic [SW-1:0]         o_im;
	} item_t;

	typedef struct packed {
		logic           is_bin;
		logic [SW-1:0]  re;
		logic [SW-1:0]  im;
		logic [SW-1:0]  magn;
	} res_t;

	function automatic logic [SW-1:0] uabs(input logic signed [SW-1:0] v);
		return v[SW-1] ? ((~v) + SW'(1)) : v;
	endfunction

	function automatic logic [SW-1:0] sat_comp(input logic neg, input logic [PN-1:0] q);
		logic [PN-1:0] lim;
		logic [PN-1:0] qq;
		lim = neg ? NEG_LIM : POS_LIM;
		qq = (q > lim) ? lim : q;
		return neg ? ((~qq[SW-1:0]) + SW'(1)) : qq[SW-1:0];
	endfunction

	// configuration
	mode_t      mode_q;
	logic       curve_en_q;
	logic [7:0] eps_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_LEARN;
			curve_en_q <= 1'b0;
			eps_q      <= EPS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE:  mode_q     <= mode_t'(cfg_data[1:0]);
				CFG_CURVE: curve_en_q <= cfg_data[0];
				CFG_EPS:   eps_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic            pipe_adv;
	logic            emit;
	logic [LAST:0]   vld_q;
	logic            res_vld_q;
	logic            skid_vld_q;
	logic            load_out;
	logic            item_fire;
	logic [AW-1:0]   tbl_idx;

	assign pipe_adv   = !skid_vld_q;
	assign item_stall = skid_vld_q;
	assign item_fire  = item_valid && pipe_adv;
	assign emit       = vld_q[LAST] && pipe_adv;
	assign tbl_idx    = AW'(bin_index);

	// learned gain memory, read at the input transfer
	logic [GAIN_WIDTH-1:0] gain_mem [BINS];
	logic [GAIN_WIDTH-1:0] gain_rd_q;

	always_ff @(posedge clk) begin
		if (item_fire && op) begin
			gain_mem[tbl_idx] <= gain_value;
		end
		if (pipe_adv) begin
			gain_rd_q <= gain_mem[tbl_idx];
		end
	end

	item_t pl_q [0:LAST];
	item_t nx_c [1:LAST];
	item_t in_item;

	always_comb begin
		in_item       = '0;
		in_item.is_wr = op;
		in_item.sr    = sig_re;
		in_item.si    = sig_im;
		in_item.rr    = ref_re;
		in_item.ri    = ref_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pipe_adv) begin
			vld_q <= {vld_q[LAST-1:0], item_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_adv) begin
			pl_q[0] <= in_item;
			for (int k = 1; k <= LAST; k++) begin
				pl_q[k] <= nx_c[k];
			end
		end
	end

	// squares of both bins, gain select
	always_comb begin
		logic [SQW-1:0] p1, p2, p3, p4;
		nx_c[ISQ0]       = pl_q[0];
		nx_c[ISQ0].g     = curve_en_q ? {1'b0, gain_rd_q} : ONE_G;
		p1 = uabs(pl_q[0].sr) * uabs(pl_q[0].sr);
		p2 = uabs(pl_q[0].si) * uabs(pl_q[0].si);
		p3 = uabs(pl_q[0].rr) * uabs(pl_q[0].rr);
		p4 = uabs(pl_q[0].ri) * uabs(pl_q[0].ri);
		nx_c[ISQ0].v_sig = p1 + p2;
		nx_c[ISQ0].v_ref = p3 + p4;
		nx_c[ISQ0].r_sig = '0;
		nx_c[ISQ0].r_ref = '0;
	end

	// input magnitudes, one root bit per stage
	for (genvar k = 0; k < SW; k++) begin : g_isq_in
		localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * k);
		always_comb begin
			nx_c[ISQ0+k+1] = pl_q[ISQ0+k];
			if (pl_q[ISQ0+k].v_sig >= pl_q[ISQ0+k].r_sig + BIT) begin
				nx_c[ISQ0+k+1].v_sig = pl_q[ISQ0+k].v_sig - (pl_q[ISQ0+k].r_sig + BIT);
				nx_c[ISQ0+k+1].r_sig = (pl_q[ISQ0+k].r_sig >> 1) + BIT;
			end else begin
				nx_c[ISQ0+k+1].r_sig = pl_q[ISQ0+k].r_sig >> 1;
			end
			if (pl_q[ISQ0+k].v_ref >= pl_q[ISQ0+k].r_ref + BIT) begin
				nx_c[ISQ0+k+1].v_ref = pl_q[ISQ0+k].v_ref - (pl_q[ISQ0+k].r_ref + BIT);
				nx_c[ISQ0+k+1].r_ref = (pl_q[ISQ0+k].r_ref >> 1) + BIT;
			end else begin
				nx_c[ISQ0+k+1].r_ref = pl_q[ISQ0+k].r_ref >> 1;
			end
		end
	end

	// divider operands by mode
	always_comb begin
		logic [SW-1:0] smag, emag;
		smag = pl_q[PRE].r_sig[SW-1:0];
		emag = pl_q[PRE].r_ref[SW-1:0];
		nx_c[DV1]         = pl_q[PRE];
		nx_c[DV1].sm      = smag;
		nx_c[DV1].d1_rem  = '0;
		nx_c[DV1].d1_num  = '0;
		nx_c[DV1].d1_dvs  = '0;
		nx_c[DV1].use_div = 1'b0;
		case (mode_q)
			MODE_LEARN: begin
				nx_c[DV1].d1_num  = (D1W'(emag) << F) + D1W'(smag >> 1);
				nx_c[DV1].d1_dvs  = D1V'(smag);
				nx_c[DV1].use_div = smag > SW'(eps_q);
			end
			MODE_GUESS: begin
				nx_c[DV1].d1_num  = (D1W'(smag) << F) + D1W'(emag >> 1);
				nx_c[DV1].d1_dvs  = D1V'(emag);
				nx_c[DV1].use_div = emag > SW'(eps_q);
			end
			MODE_INV: begin
				nx_c[DV1].d1_num  = (D1W'(smag) << F) + D1W'(pl_q[PRE].g >> 1);
				nx_c[DV1].d1_dvs  = D1V'(pl_q[PRE].g);
				nx_c[DV1].use_div = pl_q[PRE].g != '0;
			end
			default: ;
		endcase
	end

	// ratio divider, quotient shifts into the numerator register
	for (genvar k = 0; k < D1W; k++) begin : g_div1
		always_comb begin
			logic [D1V:0] t;
			logic         qb;
			t  = {pl_q[DV1+k].d1_rem, pl_q[DV1+k].d1_num[D1W-1]};
			qb = t >= {1'b0, pl_q[DV1+k].d1_dvs};
			nx_c[DV1+k+1] = pl_q[DV1+k];
			nx_c[DV1+k+1].d1_rem = qb ? D1V'(t - {1'b0, pl_q[DV1+k].d1_dvs}) : t[D1V-1:0];
			nx_c[DV1+k+1].d1_num = {pl_q[DV1+k].d1_num[D1W-2:0], qb};
		end
	end

	// cap the ratio, pick the multiplier operand
	always_comb begin
		logic [NW-1:0] ncap;
		ncap = (pl_q[PST].d1_num > D1W'(N_MAX)) ? N_MAX : pl_q[PST].d1_num[NW-1:0];
		nx_c[MUL] = pl_q[PST];
		case (mode_q)
			MODE_LEARN, MODE_GUESS: nx_c[MUL].n = pl_q[PST].use_div ? ncap : ONE_N;
			MODE_INV:               nx_c[MUL].n = pl_q[PST].use_div ? ncap : NW'(1);
			MODE_APPLY:             nx_c[MUL].n = NW'(pl_q[PST].sm);
			default:                nx_c[MUL].n = ncap;
		endcase
	end

	always_comb begin
		nx_c[RND]      = pl_q[MUL];
		nx_c[RND].prod = pl_q[MUL].n * pl_q[MUL].g;
	end

	// round and cap the gain product
	always_comb begin
		logic [PW:0]   t;
		logic [NW-1:0] ncap;
		logic          gnz;
		t    = ({1'b0, pl_q[RND].prod} + HALF_P) >> F;
		ncap = (t > (PW + 1)'(N_MAX)) ? N_MAX : t[NW-1:0];
		gnz  = pl_q[RND].g != '0;
		nx_c[SCL] = pl_q[RND];
		case (mode_q)
			MODE_GUESS: begin
				if (gnz) begin
					nx_c[SCL].n = ncap;
				end
			end
			MODE_APPLY: nx_c[SCL].n = gnz ? ncap : NW'(1);
			default: ;
		endcase
	end

	// component times new magnitude, plus half the divisor
	always_comb begin
		logic [SW+NW-1:0] pr, pi;
		pr = uabs(pl_q[SCL].sr) * pl_q[SCL].n;
		pi = uabs(pl_q[SCL].si) * pl_q[SCL].n;
		nx_c[DV2]        = pl_q[SCL];
		nx_c[DV2].re_num = PN'(pr) + PN'(pl_q[SCL].sm >> 1);
		nx_c[DV2].im_num = PN'(pi) + PN'(pl_q[SCL].sm >> 1);
		nx_c[DV2].re_rem = '0;
		nx_c[DV2].im_rem = '0;
	end

	// component dividers by the signal magnitude
	for (genvar k = 0; k < PN; k++) begin : g_div2
		always_comb begin
			logic [SW:0] tr, ti;
			logic        qr, qi;
			tr = {pl_q[DV2+k].re_rem, pl_q[DV2+k].re_num[PN-1]};
			ti = {pl_q[DV2+k].im_rem, pl_q[DV2+k].im_num[PN-1]};
			qr = tr >= {1'b0, pl_q[DV2+k].sm};
			qi = ti >= {1'b0, pl_q[DV2+k].sm};
			nx_c[DV2+k+1] = pl_q[DV2+k];
			nx_c[DV2+k+1].re_rem = qr ? SW'(tr - {1'b0, pl_q[DV2+k].sm}) : tr[SW-1:0];
			nx_c[DV2+k+1].im_rem = qi ? SW'(ti - {1'b0, pl_q[DV2+k].sm}) : ti[SW-1:0];
			nx_c[DV2+k+1].re_num = {pl_q[DV2+k].re_num[PN-2:0], qr};
			nx_c[DV2+k+1].im_num = {pl_q[DV2+k].im_num[PN-2:0], qi};
		end
	end

	// restore sign and saturate; zero bin and table write give zeros
	always_comb begin
		nx_c[OSQ] = pl_q[SAT];
		if (pl_q[SAT].is_wr || pl_q[SAT].sm == '0) begin
			nx_c[OSQ].o_re = '0;
			nx_c[OSQ].o_im = '0;
		end else begin
			nx_c[OSQ].o_re = sat_comp(pl_q[SAT].sr[SW-1], pl_q[SAT].re_num);
			nx_c[OSQ].o_im = sat_comp(pl_q[SAT].si[SW-1], pl_q[SAT].im_num);
		end
	end

	always_comb begin
		logic [SQW-1:0] p1, p2;
		p1 = uabs(pl_q[OSQ].o_re) * uabs(pl_q[OSQ].o_re);
		p2 = uabs(pl_q[OSQ].o_im) * uabs(pl_q[OSQ].o_im);
		nx_c[OIS]       = pl_q[OSQ];
		nx_c[OIS].v_sig = p1 + p2;
		nx_c[OIS].r_sig = '0;
	end

	// output magnitude
	for (genvar k = 0; k < SW; k++) begin : g_isq_out
		localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * k);
		always_comb begin
			nx_c[OIS+k+1] = pl_q[OIS+k];
			if (pl_q[OIS+k].v_sig >= pl_q[OIS+k].r_sig + BIT) begin
				nx_c[OIS+k+1].v_sig = pl_q[OIS+k].v_sig - (pl_q[OIS+k].r_sig + BIT);
				nx_c[OIS+k+1].r_sig = (pl_q[OIS+k].r_sig >> 1) + BIT;
			end else begin
				nx_c[OIS+k+1].r_sig = pl_q[OIS+k].r_sig >> 1;
			end
		end
	end

	// output register and skid stage
	res_t res_c;
	res_t res_q;
	res_t skid_q;

	always_comb begin
		res_c.is_bin = !pl_q[LAST].is_wr;
		res_c.re     = pl_q[LAST].o_re;
		res_c.im     = pl_q[LAST].o_im;
		res_c.magn   = (pl_q[LAST].r_sig > SQW'({SW{1'b1}})) ? {SW{1'b1}}
			: pl_q[LAST].r_sig[SW-1:0];
	end

	assign load_out = emit ? (!res_vld_q || !res_stall) : (skid_vld_q && !res_stall);

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q <= emit ? res_c : skid_q;
		end
		if (emit && res_vld_q && res_stall) begin
			skid_q <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (emit) begin
			if (res_vld_q && res_stall) begin
				skid_vld_q <= 1'b1;
			end else begin
				res_vld_q <= 1'b1;
			end
		end else if (skid_vld_q) begin
			if (!res_stall) begin
				skid_vld_q <= 1'b0;
			end
		end else if (res_vld_q && !res_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	assign res_valid = res_vld_q;
	assign is_bin    = res_q.is_bin;
	assign out_re    = res_q.re;
	assign out_im    = res_q.im;
	assign out_magn  = res_q.magn;

	`SBGM_ASSERT_NEXT(a_skid_fill, emit && res_vld_q && res_stall, skid_vld_q, "result lost on stall")
	`SBGM_ASSERT_SAME(a_skid_behind_out, skid_vld_q, res_vld_q, "skid full with output empty")
	`SBGM_ASSERT_NEXT(a_pipe_frozen, skid_vld_q, $stable(vld_q), "pipeline moved while frozen")
	`SBGM_ASSERT_SAME(a_wr_ack_zero, res_vld_q && !res_q.is_bin, res_q.magn == '0 && res_q.re == '0 && res_q.im == '0, "write transfer not zero")

endmodule

`default_nettype wire
